>>> design/pressure_sensor_poll_convert_tare_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure sensor poll, convert and tare core
// Shared property templates, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_POLL_CONVERT_TARE_CORE_DEFINES_SVH
`define PRESSURE_SENSOR_POLL_CONVERT_TARE_CORE_DEFINES_SVH

// Same-cycle implication.
`define PSPCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSPCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pspct_pkg.sv
// ----------------------------------------------------------------------------
// pspct_pkg
// Types, codes and constants of the pressure sensor poll, convert and tare core.
// ----------------------------------------------------------------------------
`default_nettype none

package pspct_pkg;

  // Field widths
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STATUS_W  = 8;
  localparam int unsigned COUNTS_W  = 24;
  localparam int unsigned RESULT_W  = 2;
  localparam int unsigned PRESS_W   = 32;
  localparam int unsigned PRANGE_W  = 22;
  localparam int unsigned LIMIT_W   = 21;
  localparam int unsigned CONV_W    = 8;

  // Configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Conversion datapath widths
  localparam int unsigned DIFF_W = COUNTS_W + 1;        // counts minus offset
  localparam int unsigned PSPAN_W = PRANGE_W + 1;       // pressure span
  localparam int unsigned PROD_W = DIFF_W + PSPAN_W;    // product of both
  localparam int unsigned DVS_W  = DIFF_W;              // divisor magnitude

  // Sensor status byte bits
  localparam int unsigned ST_BUSY_BIT   = 5;
  localparam int unsigned ST_MEMERR_BIT = 2;

  // Register reset values
  localparam logic [COUNTS_W-1:0] OUT_MIN_RST  = 24'd1677722;
  localparam logic [COUNTS_W-1:0] OUT_MAX_RST  = 24'd15099494;
  localparam logic [PRANGE_W-1:0] P_MIN_RST    = 22'd0;
  localparam logic [PRANGE_W-1:0] P_MAX_RST    = 22'd30000;
  localparam logic [LIMIT_W-1:0]  TARE_LIM_RST = 21'd500;
  localparam logic [CONV_W-1:0]   CONV_T_RST   = 8'd5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UPDATE   = 3'd0,
    ACT_ZERO     = 3'd1,
    ACT_ZERO_RST = 3'd2,
    ACT_STATUS   = 3'd3,
    ACT_REINIT   = 3'd4
  } action_e;

  typedef enum logic [RESULT_W-1:0] {
    RES_OK   = 2'd0,
    RES_BUSY = 2'd1,
    RES_ERR  = 2'd2
  } result_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OUT_MIN  = 3'd0,
    REG_OUT_MAX  = 3'd1,
    REG_P_MIN    = 3'd2,
    REG_P_MAX    = 3'd3,
    REG_TARE_LIM = 3'd4,
    REG_CONV_T   = 3'd5
  } reg_idx_e;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> design/pspct_req_if.sv
// ----------------------------------------------------------------------------
// pspct_req_if
// Request channel: one action per transfer with the bus outcomes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pspct_req_if
  import pspct_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TIME_W-1:0]   now_ms;
  logic                write_ok;
  logic                read_ok;
  logic [STATUS_W-1:0] rx_status;
  logic [COUNTS_W-1:0] rx_counts;

  modport source (
    output valid, action, now_ms, write_ok, read_ok, rx_status, rx_counts,
    input  ready
  );
  modport sink (
    input  valid, action, now_ms, write_ok, read_ok, rx_status, rx_counts,
    output ready
  );
endinterface

`default_nettype wire

>>> design/pspct_rsp_if.sv
// ----------------------------------------------------------------------------
// pspct_rsp_if
// Response channel: one result transfer for every request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pspct_rsp_if
  import pspct_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result_code;
  logic                issue_measure;
  logic                issue_read;
  logic signed [PRESS_W-1:0] pressure_x100;
  logic [STATUS_W-1:0] last_status_byte;
  logic                zero_refused;

  modport source (
    output valid, result_code, issue_measure, issue_read, pressure_x100,
           last_status_byte, zero_refused,
    input  ready
  );
  modport sink (
    input  valid, result_code, issue_measure, issue_read, pressure_x100,
           last_status_byte, zero_refused,
    output ready
  );
endinterface

`default_nettype wire

>>> design/pspct_div.sv
// ----------------------------------------------------------------------------
// pspct_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pspct_div
  import pspct_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PROD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0]  divisor_i,
  output logic      [PROD_W-1:0] quotient_o,
  output div_stat_t              status_o
);

  localparam int unsigned CNT_W = $clog2(PROD_W + 1);

  logic [DVS_W-1:0]  rem_q;
  logic [PROD_W-1:0] dvd_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  trial;
  logic              borrow;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_q, dvd_q[PROD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign borrow  = trial[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= borrow ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_q <= {dvd_q[PROD_W-2:0], ~borrow};
    end
  end

  assign quotient_o    = dvd_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

`default_nettype wire

>>> design/pressure_sensor_poll_convert_tare_core.sv
// ----------------------------------------------------------------------------
// pressure_sensor_poll_convert_tare_core
// Polls a digital pressure sensor, converts counts to hundredths and tares.
// A good frame passes through the multiply state, the divider start state,
// the divide state until the divider finishes, the scaling state and the
// commit; the next request is taken once the commit has returned to idle.
// A frame with a zero count span goes from the multiply state straight to
// the commit, and every other action goes straight to the commit. A result
// that waits at the output holds the next request in its commit state.
// Reset clears the poll state, the tare and the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pressure_sensor_poll_convert_tare_core_defines.svh"

module pressure_sensor_poll_convert_tare_core
  import pspct_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  pspct_req_if.sink                  req_i,
  pspct_rsp_if.source                rsp_o
);

  // Count bits kept from the 24-bit field.
  localparam int unsigned KEEP_BITS = (COUNT_BITS < COUNTS_W) ? COUNT_BITS : COUNTS_W;
  localparam int unsigned SUM_W     = PROD_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_FIN,
    S_DONE
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COUNTS_W-1:0] out_min_q, out_max_q;
  logic [PRANGE_W-1:0] p_min_q, p_max_q;
  logic [LIMIT_W-1:0]  tare_lim_q;
  logic [CONV_W-1:0]   conv_t_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_min_q  <= OUT_MIN_RST;
      out_max_q  <= OUT_MAX_RST;
      p_min_q    <= P_MIN_RST;
      p_max_q    <= P_MAX_RST;
      tare_lim_q <= TARE_LIM_RST;
      conv_t_q   <= CONV_T_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OUT_MIN:  out_min_q  <= pwdata[COUNTS_W-1:0];
        REG_OUT_MAX:  out_max_q  <= pwdata[COUNTS_W-1:0];
        REG_P_MIN:    p_min_q    <= pwdata[PRANGE_W-1:0];
        REG_P_MAX:    p_max_q    <= pwdata[PRANGE_W-1:0];
        REG_TARE_LIM: tare_lim_q <= pwdata[LIMIT_W-1:0];
        REG_CONV_T:   conv_t_q   <= pwdata[CONV_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback, zero extended.
  always_comb begin
    unique case (cfg_idx)
      REG_OUT_MIN:  prdata = APB_DATA_W'(out_min_q);
      REG_OUT_MAX:  prdata = APB_DATA_W'(out_max_q);
      REG_P_MIN:    prdata = APB_DATA_W'(p_min_q);
      REG_P_MAX:    prdata = APB_DATA_W'(p_max_q);
      REG_TARE_LIM: prdata = APB_DATA_W'(tare_lim_q);
      REG_CONV_T:   prdata = APB_DATA_W'(conv_t_q);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state, poll state and latched request
  // --------------------------------------------------------------------------
  state_e                    state_q;
  logic                      waiting_q;
  logic [TIME_W-1:0]         cmd_time_q;
  logic signed [PRESS_W-1:0] raw_q, tare_q;
  logic [STATUS_W-1:0]       status_q;

  logic [ACTION_W-1:0]       act_q;
  logic [TIME_W-1:0]         now_q;
  logic                      wok_q, rok_q;
  logic [STATUS_W-1:0]       rxs_q;
  logic [KEEP_BITS-1:0]      counts_q;

  logic signed [PROD_W-1:0]  prod_q;
  logic                      neg_q;
  logic [DVS_W-1:0]          span_mag_q;
  logic signed [PRESS_W-1:0] conv_raw_q;

  logic                      out_valid_q;
  logic [RESULT_W-1:0]       out_res_q;
  logic                      out_meas_q, out_rd_q, out_ref_q;
  logic signed [PRESS_W-1:0] out_press_q;
  logic [STATUS_W-1:0]       out_stat_q;

  logic                      accept, commit, need_conv;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // A good frame needs the counts conversion.
  always_comb begin
    logic [TIME_W-1:0] el;
    el = req_i.now_ms - cmd_time_q;
    need_conv = (req_i.action == ACT_UPDATE) && waiting_q
             && !(el < TIME_W'(conv_t_q)) && req_i.read_ok
             && !req_i.rx_status[ST_BUSY_BIT] && !req_i.rx_status[ST_MEMERR_BIT];
  end

  // --------------------------------------------------------------------------
  // Conversion datapath: one multiply, then the divider
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]  cnt_diff, span_c;
  logic signed [PSPAN_W-1:0] p_span;
  logic signed [PROD_W-1:0]  prod_d;
  logic [PROD_W-1:0]         prod_mag;
  logic [PROD_W-1:0]         quot;
  div_stat_t                 div_st;
  logic                      div_start;

  assign cnt_diff = $signed({{(DIFF_W-KEEP_BITS){1'b0}}, counts_q})
                  - $signed({1'b0, out_min_q});
  assign span_c   = $signed({1'b0, out_max_q}) - $signed({1'b0, out_min_q});
  assign p_span   = $signed({p_max_q[PRANGE_W-1], p_max_q})
                  - $signed({p_min_q[PRANGE_W-1], p_min_q});
  assign prod_d   = cnt_diff * p_span;
  assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign div_start = (state_q == S_DIV_GO);

  pspct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_mag),
    .divisor_i  (span_mag_q),
    .quotient_o (quot),
    .status_o   (div_st)
  );

  // Saturate a wide signed value to the 32-bit pressure range.
  function automatic logic signed [PRESS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'({1'b0, {(PRESS_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi)      sat32 = {1'b0, {(PRESS_W-1){1'b1}}};
    else if (v < lo) sat32 = {1'b1, {(PRESS_W-1){1'b0}}};
    else             sat32 = v[PRESS_W-1:0];
  endfunction

  // Sign the quotient, add the range offset and saturate.
  logic signed [SUM_W-1:0] q_signed, conv_sum;
  assign q_signed = neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign conv_sum = q_signed + SUM_W'($signed(p_min_q));

  // --------------------------------------------------------------------------
  // Commit of one request
  // --------------------------------------------------------------------------
  logic                      waiting_d;
  logic [TIME_W-1:0]         cmd_time_d;
  logic signed [PRESS_W-1:0] raw_d, tare_d;
  logic [STATUS_W-1:0]       status_d;
  logic [RESULT_W-1:0]       res_d;
  logic                      meas_d, rd_d, ref_d;
  logic signed [PRESS_W-1:0] press_d;

  always_comb begin
    logic [TIME_W-1:0]     el;
    logic signed [PRESS_W:0] lim;
    el         = now_q - cmd_time_q;
    lim        = (PRESS_W+1)'(tare_lim_q);
    waiting_d  = waiting_q;
    cmd_time_d = cmd_time_q;
    raw_d      = raw_q;
    tare_d     = tare_q;
    status_d   = status_q;
    res_d      = RES_OK;
    meas_d     = 1'b0;
    rd_d       = 1'b0;
    ref_d      = 1'b0;
    case (act_q)
      ACT_UPDATE: begin
        if (!waiting_q) begin
          meas_d = 1'b1;
          if (wok_q) begin
            cmd_time_d = now_q;
            waiting_d  = 1'b1;
            res_d      = RES_BUSY;
          end else begin
            res_d = RES_ERR;
          end
        end else if (el < TIME_W'(conv_t_q)) begin
          res_d = RES_BUSY;
        end else begin
          rd_d = 1'b1;
          if (!rok_q) begin
            waiting_d = 1'b0;
            res_d     = RES_ERR;
          end else begin
            status_d = rxs_q;
            if (rxs_q[ST_BUSY_BIT]) begin
              res_d = RES_BUSY;
            end else if (rxs_q[ST_MEMERR_BIT]) begin
              waiting_d = 1'b0;
              res_d     = RES_ERR;
            end else begin
              raw_d  = conv_raw_q;
              meas_d = 1'b1;
              if (wok_q) cmd_time_d = now_q;
              else       waiting_d  = 1'b0;
            end
          end
        end
      end
      ACT_ZERO: begin
        if ($signed({raw_q[PRESS_W-1], raw_q}) > lim ||
            $signed({raw_q[PRESS_W-1], raw_q}) < -lim) begin
          ref_d = 1'b1;
        end else begin
          tare_d = raw_q;
        end
      end
      ACT_ZERO_RST: tare_d = '0;
      ACT_STATUS: ;
      ACT_REINIT: begin
        waiting_d = 1'b0;
        raw_d     = '0;
        status_d  = '0;
      end
      default: res_d = RES_ERR;
    endcase
    press_d = sat32(SUM_W'(raw_d) - SUM_W'(tare_d));
  end

  // --------------------------------------------------------------------------
  // Sequencer with poll state and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      waiting_q   <= 1'b0;
      cmd_time_q  <= '0;
      raw_q       <= '0;
      tare_q      <= '0;
      status_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result replaces the one that leaves in the same cycle.
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (accept) state_q <= need_conv ? S_MUL : S_DONE;
        S_MUL: state_q <= (span_c == '0) ? S_DONE : S_DIV_GO;
        S_DIV_GO: state_q <= S_DIV;
        S_DIV: if (div_st.done) state_q <= S_FIN;
        S_FIN: state_q <= S_DONE;
        S_DONE: begin
          if (commit) begin
            state_q     <= S_IDLE;
            waiting_q   <= waiting_d;
            cmd_time_q  <= cmd_time_d;
            raw_q       <= raw_d;
            tare_q      <= tare_d;
            status_q    <= status_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers: request latch, conversion values and result fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= req_i.action;
      now_q    <= req_i.now_ms;
      wok_q    <= req_i.write_ok;
      rok_q    <= req_i.read_ok;
      rxs_q    <= req_i.rx_status;
      counts_q <= req_i.rx_counts[KEEP_BITS-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q     <= prod_d;
      neg_q      <= prod_d[PROD_W-1] ^ span_c[DIFF_W-1];
      span_mag_q <= span_c[DIFF_W-1] ? DVS_W'(-span_c) : DVS_W'(span_c);
      conv_raw_q <= PRESS_W'($signed(p_min_q));
    end
    if (state_q == S_FIN) conv_raw_q <= sat32(conv_sum);
    if (commit) begin
      out_res_q   <= res_d;
      out_meas_q  <= meas_d;
      out_rd_q    <= rd_d;
      out_ref_q   <= ref_d;
      out_press_q <= press_d;
      out_stat_q  <= status_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.result_code      = out_res_q;
  assign rsp_o.issue_measure    = out_meas_q;
  assign rsp_o.issue_read       = out_rd_q;
  assign rsp_o.pressure_x100    = out_press_q;
  assign rsp_o.last_status_byte = out_stat_q;
  assign rsp_o.zero_refused     = out_ref_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PSPCT_ASSERT_NOW(a_div_only_in_div, div_st.busy, state_q == S_DIV,
                    "divider busy outside the divide state")
  `PSPCT_ASSERT_NEXT(a_good_frame_muls, accept && need_conv, state_q == S_MUL,
                     "good frame did not enter the conversion")
  `PSPCT_ASSERT_NEXT(a_commit_shows, commit, out_valid_q && state_q == S_IDLE,
                     "committed request did not produce a result")
  `PSPCT_ASSERT_NOW(a_wait_from_update, $rose(waiting_q),
                    $past(act_q) == ACT_UPDATE,
                    "poll wait entered by an action other than update")

endmodule

`default_nettype wire

>>> tb/pressure_sensor_poll_convert_tare_core_tb.sv
// ----------------------------------------------------------------------------
// pressure_sensor_poll_convert_tare_core_tb
// Self-checking testbench for the pressure sensor poll, convert and tare core.
// Requests are offered in random bursts while the result side stalls on its
// own pattern. Every accepted request is run through a local copy of the
// poll, conversion and tare behavior, and each result transfer is compared
// field by field with the oldest predicted reading. Directed sequences cover
// the poll cycle, tare handling and saturation. Random traffic then runs
// under several register settings, the range extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_sensor_poll_convert_tare_core_tb;
  import pspct_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TIME_W-1:0]   now_ms;
    logic                write_ok;
    logic                read_ok;
    logic [STATUS_W-1:0] rx_status;
    logic [COUNTS_W-1:0] rx_counts;
  } poll_req_t;

  typedef struct packed {
    logic [RESULT_W-1:0]       code;
    logic                      meas_issued;
    logic                      rd_issued;
    logic signed [PRESS_W-1:0] pressure;
    logic [STATUS_W-1:0]       status;
    logic                      refused;
  } reading_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pspct_req_if req_if ();
  pspct_rsp_if rsp_if ();

  pressure_sensor_poll_convert_tare_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  // Register shadow copy.
  logic [COUNTS_W-1:0]        cfg_out_min;
  logic [COUNTS_W-1:0]        cfg_out_max;
  logic signed [PRANGE_W-1:0] cfg_p_min;
  logic signed [PRANGE_W-1:0] cfg_p_max;
  logic [LIMIT_W-1:0]         cfg_tare_lim;
  logic [CONV_W-1:0]          cfg_conv;

  // Poll and tare state as the block should hold it.
  logic                      st_waiting;
  logic [TIME_W-1:0]         st_cmd_ms;
  logic signed [PRESS_W-1:0] st_raw;
  logic signed [PRESS_W-1:0] st_tare;
  logic [STATUS_W-1:0]       st_status;

  reading_t pending_readings[$];

  int errors;
  int readings_checked;
  int requests_sent;
  int frames_converted;
  int zeros_refused;
  int config_phases;
  int long_holds;
  int quiet_cycles;
  int burst_left;
  bit hold_request;

  // Stimulus time base for the poll sequences.
  logic [TIME_W-1:0] gen_ms;
  logic [TIME_W-1:0] gen_cmd_ms;

  // Clock: period of 4 time units.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic signed [PRESS_W-1:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Linear counts to hundredths; signed divide truncates toward zero.
  function automatic logic signed [PRESS_W-1:0] counts_to_pressure(
    input logic [COUNTS_W-1:0] counts
  );
    longint span_c;
    longint num;
    span_c = longint'(cfg_out_max) - longint'(cfg_out_min);
    if (span_c == 0) return PRESS_W'(cfg_p_min);
    num = (longint'(counts) - longint'(cfg_out_min)) *
          (longint'(cfg_p_max) - longint'(cfg_p_min));
    return sat32(num / span_c + longint'(cfg_p_min));
  endfunction

  function automatic reading_t next_reading(input poll_req_t r);
    reading_t o;
    o = '0;
    o.code = RES_OK;
    case (r.action)
      ACT_UPDATE: begin
        if (!st_waiting) begin
          o.meas_issued = 1'b1;
          if (r.write_ok) begin
            st_cmd_ms  = r.now_ms;
            st_waiting = 1'b1;
            o.code     = RES_BUSY;
          end else begin
            o.code = RES_ERR;
          end
        end else if ((r.now_ms - st_cmd_ms) < {24'd0, cfg_conv}) begin
          o.code = RES_BUSY;
        end else begin
          o.rd_issued = 1'b1;
          if (!r.read_ok) begin
            st_waiting = 1'b0;
            o.code     = RES_ERR;
          end else begin
            st_status = r.rx_status;
            if (r.rx_status[ST_BUSY_BIT]) begin
              o.code = RES_BUSY;
            end else if (r.rx_status[ST_MEMERR_BIT]) begin
              st_waiting = 1'b0;
              o.code     = RES_ERR;
            end else begin
              // Good frame: convert, then send the next measure command.
              st_raw = counts_to_pressure(r.rx_counts);
              o.meas_issued = 1'b1;
              if (r.write_ok) st_cmd_ms = r.now_ms;
              else st_waiting = 1'b0;
              frames_converted++;
            end
          end
        end
      end
      ACT_ZERO: begin
        if (longint'(st_raw) > longint'(cfg_tare_lim) ||
            longint'(st_raw) < -longint'(cfg_tare_lim)) begin
          o.refused = 1'b1;
          zeros_refused++;
        end else begin
          st_tare = st_raw;
        end
      end
      ACT_ZERO_RST: st_tare = '0;
      ACT_STATUS: ;
      ACT_REINIT: begin
        st_waiting = 1'b0;
        st_raw     = '0;
        st_status  = '0;
      end
      default: o.code = RES_ERR;
    endcase
    o.pressure = sat32(longint'(st_raw) - longint'(st_tare));
    o.status   = st_status;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("ERROR reading %0d: %s got 0x%0h, expected 0x%0h",
               readings_checked, field, got, want);
  endtask

  // Predicts on each request transfer and checks each result transfer.
  always @(posedge clk_i) begin : transfer_monitor
    poll_req_t r;
    reading_t  want;
    if (rst_ni) begin
      quiet_cycles++;
      if (psel && penable) quiet_cycles = 0;
      if (req_if.valid && req_if.ready) begin
        r.action    = req_if.action;
        r.now_ms    = req_if.now_ms;
        r.write_ok  = req_if.write_ok;
        r.read_ok   = req_if.read_ok;
        r.rx_status = req_if.rx_status;
        r.rx_counts = req_if.rx_counts;
        pending_readings.push_back(next_reading(r));
        quiet_cycles = 0;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        quiet_cycles = 0;
        if (pending_readings.size() == 0) begin
          report_mismatch("unexpected result", 32'(rsp_if.result_code), '0);
        end else begin
          want = pending_readings.pop_front();
          if (rsp_if.result_code !== want.code)
            report_mismatch("result_code", 32'(rsp_if.result_code), 32'(want.code));
          if (rsp_if.issue_measure !== want.meas_issued)
            report_mismatch("issue_measure", 32'(rsp_if.issue_measure),
                            32'(want.meas_issued));
          if (rsp_if.issue_read !== want.rd_issued)
            report_mismatch("issue_read", 32'(rsp_if.issue_read), 32'(want.rd_issued));
          if (rsp_if.pressure_x100 !== want.pressure)
            report_mismatch("pressure_x100", rsp_if.pressure_x100, want.pressure);
          if (rsp_if.last_status_byte !== want.status)
            report_mismatch("last_status_byte", 32'(rsp_if.last_status_byte),
                            32'(want.status));
          if (rsp_if.zero_refused !== want.refused)
            report_mismatch("zero_refused", 32'(rsp_if.zero_refused), 32'(want.refused));
        end
        readings_checked++;
      end
    end
  end

  // Ends the run when no transfer of any kind has happened for too long.
  initial begin : watchdog
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles without a transfer", QUIET_LIMIT);
    $display("pressure_sensor_poll_convert_tare_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stalls follow a changing pattern, plus requested long holds.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    int period;
    int phase;
    mode      = 0;
    mode_left = 50;
    hold_left = 0;
    period    = 3;
    phase     = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        long_holds++;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
        period    = $urandom_range(2, 6);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready = 1'b0;
      end else begin
        case (mode)
          0: rsp_if.ready = 1'b1;
          1: rsp_if.ready = ($urandom_range(0, 9) < 7);
          2: rsp_if.ready = ((phase % period) != 0);
          default: rsp_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side and register access
  // ---------------------------------------------------------------------------

  function automatic poll_req_t mk_req(input logic [ACTION_W-1:0] a,
                                       input logic [TIME_W-1:0] t,
                                       input logic w, input logic rd,
                                       input logic [STATUS_W-1:0] s,
                                       input logic [COUNTS_W-1:0] c);
    poll_req_t r;
    r.action    = a;
    r.now_ms    = t;
    r.write_ok  = w;
    r.read_ok   = rd;
    r.rx_status = s;
    r.rx_counts = c;
    return r;
  endfunction

  // Request with random bus outcomes and sensor data.
  function automatic poll_req_t mk_noise(input logic [ACTION_W-1:0] a,
                                         input logic [TIME_W-1:0] t);
    return mk_req(a, t, 1'($urandom), 1'($urandom), STATUS_W'($urandom),
                  COUNTS_W'($urandom));
  endfunction

  // Offers one request and waits for its transfer; bursts end in a gap.
  task automatic offer(input poll_req_t r);
    @(negedge clk_i);
    req_if.valid     = 1'b1;
    req_if.action    = r.action;
    req_if.now_ms    = r.now_ms;
    req_if.write_ok  = r.write_ok;
    req_if.read_ok   = r.read_ok;
    req_if.rx_status = r.rx_status;
    req_if.rx_counts = r.rx_counts;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    requests_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Stops offering and waits until every predicted reading has arrived.
  task automatic settle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register, then reads it back.
  task automatic write_reg(input reg_idx_e idx, input logic [APB_DATA_W-1:0] val);
    logic [APB_DATA_W-1:0] want;
    case (idx) inside
      REG_OUT_MIN, REG_OUT_MAX: want = APB_DATA_W'(val[COUNTS_W-1:0]);
      REG_P_MIN, REG_P_MAX:     want = APB_DATA_W'(val[PRANGE_W-1:0]);
      REG_TARE_LIM:             want = APB_DATA_W'(val[LIMIT_W-1:0]);
      REG_CONV_T:               want = APB_DATA_W'(val[CONV_W-1:0]);
      default:                  want = '0;
    endcase
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    // Read transfer of the same register.
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_OUT_MIN:  cfg_out_min  = val[COUNTS_W-1:0];
      REG_OUT_MAX:  cfg_out_max  = val[COUNTS_W-1:0];
      REG_P_MIN:    cfg_p_min    = val[PRANGE_W-1:0];
      REG_P_MAX:    cfg_p_max    = val[PRANGE_W-1:0];
      REG_TARE_LIM: cfg_tare_lim = val[LIMIT_W-1:0];
      REG_CONV_T:   cfg_conv     = val[CONV_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all six registers once the block has gone idle.
  task automatic set_config(input logic [COUNTS_W-1:0] omin, input logic [COUNTS_W-1:0] omax,
                            input int pmin, input int pmax,
                            input logic [LIMIT_W-1:0] lim, input logic [CONV_W-1:0] conv);
    settle();
    write_reg(REG_OUT_MIN, 32'(omin));
    write_reg(REG_OUT_MAX, 32'(omax));
    write_reg(REG_P_MIN, 32'(pmin));
    write_reg(REG_P_MAX, 32'(pmax));
    write_reg(REG_TARE_LIM, 32'(lim));
    write_reg(REG_CONV_T, 32'(conv));
    config_phases++;
  endtask

  // Status byte: mostly a good frame, sometimes busy or memory error.
  function automatic logic [STATUS_W-1:0] pick_status();
    logic [STATUS_W-1:0] s;
    int k;
    s = STATUS_W'($urandom);
    k = $urandom_range(0, 99);
    if (k < 80) return s & ~8'h24;
    if (k < 90) return s | 8'h20;
    return (s & ~8'h20) | 8'h04;
  endfunction

  function automatic logic [COUNTS_W-1:0] pick_counts();
    case ($urandom_range(0, 5))
      3: return cfg_out_min + COUNTS_W'($urandom_range(0, 128)) - 24'd64;
      4: return ($urandom_range(0, 1) == 1) ? 24'hffffff : 24'h000000;
      5: return cfg_out_max;
      default: return COUNTS_W'($urandom);
    endcase
  endfunction

  // One poll cycle: measure command, early ticks, then the data read.
  task automatic run_poll_episode();
    logic [STATUS_W-1:0] s;
    int n_early;
    if ($urandom_range(0, 49) == 0) gen_ms = $urandom;
    else gen_ms = gen_ms + TIME_W'(cfg_conv) + TIME_W'($urandom_range(0, 20));
    gen_cmd_ms = gen_ms;
    offer(mk_req(ACT_UPDATE, gen_ms, ($urandom_range(0, 9) != 0), 1'b1,
                 pick_status() & ~8'h20, pick_counts()));
    n_early = (cfg_conv == 0) ? 0 : $urandom_range(0, 2);
    repeat (n_early)
      offer(mk_noise(ACT_UPDATE, gen_cmd_ms + TIME_W'($urandom_range(0, cfg_conv - 1))));
    gen_ms = gen_cmd_ms + TIME_W'(cfg_conv) + TIME_W'($urandom_range(0, 3));
    s = pick_status();
    offer(mk_req(ACT_UPDATE, gen_ms, ($urandom_range(0, 9) != 0),
                 ($urandom_range(0, 15) != 0), s, pick_counts()));
    if (s[ST_BUSY_BIT]) begin
      gen_ms = gen_ms + TIME_W'($urandom_range(1, 4));
      offer(mk_req(ACT_UPDATE, gen_ms, 1'($urandom), 1'b1, pick_status(), pick_counts()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh state after reset, and the undefined action codes.
  task automatic test_reset_state();
    offer(mk_req(ACT_STATUS, '0, 1'b0, 1'b0, 8'h00, 24'h000000));
    offer(mk_req(3'd5, 32'hffffffff, 1'b1, 1'b1, 8'hff, 24'hffffff));
    offer(mk_req(3'd7, 32'h00000000, 1'b1, 1'b1, 8'hff, 24'hffffff));
  endtask

  // Every branch of the poll cycle under the default registers.
  task automatic test_poll_cycle();
    logic [TIME_W-1:0] t;
    t = 32'h0000_1000;
    settle();
    // Measure command not acknowledged, then acknowledged.
    offer(mk_req(ACT_UPDATE, t, 1'b0, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_UPDATE, t, 1'b1, 1'b0, 8'h00, 24'h0));
    // One millisecond short of the conversion time, then a failed read.
    offer(mk_req(ACT_UPDATE, t + 32'd4, 1'b1, 1'b1, 8'h00, 24'h0));
    offer(mk_req(ACT_UPDATE, t + 32'd5, 1'b1, 1'b0, 8'h00, 24'h0));
    // Sensor still busy, then a memory error.
    offer(mk_req(ACT_UPDATE, t + 32'd10, 1'b1, 1'b1, 8'h00, 24'h0));
    offer(mk_req(ACT_UPDATE, t + 32'd15, 1'b1, 1'b1, 8'h20, 24'h0));
    offer(mk_req(ACT_UPDATE, t + 32'd16, 1'b1, 1'b1, 8'h04, 24'h0));
    // Elapsed time across the wrap of the millisecond counter.
    offer(mk_req(ACT_UPDATE, 32'hffff_fffe, 1'b1, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_UPDATE, 32'h0000_0003, 1'b0, 1'b1, 8'hdb, cfg_out_min));
    // Full-scale frame with the next command acknowledged.
    offer(mk_req(ACT_UPDATE, 32'd100, 1'b1, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_UPDATE, 32'd105, 1'b1, 1'b1, 8'h00, 24'hffffff));
    // Zero refused at full scale, then reinit clears raw and status.
    offer(mk_req(ACT_ZERO, 32'd106, 1'b0, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_REINIT, 32'd107, 1'b0, 1'b0, 8'h00, 24'h0));
  endtask

  // Tare at the limit, then conversions that saturate high and low.
  task automatic test_tare_saturation();
    set_config(24'h800000, 24'h800001, -2000000, 2000000, 21'd2000000, 8'd0);
    offer(mk_req(ACT_UPDATE, 32'd500, 1'b1, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_UPDATE, 32'd500, 1'b1, 1'b1, 8'h00, 24'h800000));
    offer(mk_req(ACT_ZERO, 32'd501, 1'b0, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_UPDATE, 32'd502, 1'b1, 1'b1, 8'h00, 24'hffffff));
    offer(mk_req(ACT_ZERO, 32'd503, 1'b0, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_UPDATE, 32'd504, 1'b1, 1'b1, 8'h00, 24'h000000));
    offer(mk_req(ACT_ZERO_RST, 32'd505, 1'b0, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_STATUS, 32'd506, 1'b0, 1'b0, 8'h00, 24'h0));
    offer(mk_req(ACT_REINIT, 32'd507, 1'b0, 1'b0, 8'h00, 24'h0));
  endtask

  // Long output stall while requests keep coming, so the input backs up.
  task automatic test_output_stall();
    settle();
    hold_request = 1'b1;
    repeat (12)
      offer(mk_noise(($urandom_range(0, 1) == 1) ? ACT_STATUS : ACT_ZERO_RST, $urandom));
    settle();
  endtask

  // Random mix: mostly poll cycles, plus tare, status, reinit and noise.
  task automatic test_random_traffic(input int count);
    int first;
    int k;
    first = requests_sent;
    while (requests_sent - first < count) begin
      k = $urandom_range(0, 99);
      if (k < 68) begin
        run_poll_episode();
      end else if (k < 80) begin
        case ($urandom_range(0, 3))
          0, 1: offer(mk_noise(ACT_ZERO, $urandom));
          2: offer(mk_noise(ACT_ZERO_RST, $urandom));
          default: offer(mk_noise(ACT_STATUS, $urandom));
        endcase
      end else if (k < 86) begin
        offer(mk_noise(ACT_REINIT, $urandom));
      end else if (k < 91) begin
        offer(mk_noise(3'($urandom_range(5, 7)), $urandom));
      end else begin
        offer(mk_noise(ACTION_W'($urandom), $urandom));
      end
    end
  endtask

  task automatic test_random_settings(input int phases, input int count);
    repeat (phases) begin
      set_config(COUNTS_W'($urandom), COUNTS_W'($urandom),
                 int'($urandom_range(0, 4000000)) - 2000000,
                 int'($urandom_range(0, 4000000)) - 2000000,
                 LIMIT_W'($urandom_range(0, 2000000)), CONV_W'($urandom_range(0, 255)));
      test_random_traffic(count);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.action    = '0;
    req_if.now_ms    = '0;
    req_if.write_ok  = 1'b0;
    req_if.read_ok   = 1'b0;
    req_if.rx_status = '0;
    req_if.rx_counts = '0;
    cfg_out_min  = OUT_MIN_RST;
    cfg_out_max  = OUT_MAX_RST;
    cfg_p_min    = P_MIN_RST;
    cfg_p_max    = P_MAX_RST;
    cfg_tare_lim = TARE_LIM_RST;
    cfg_conv     = CONV_T_RST;
    st_waiting   = 1'b0;
    st_cmd_ms    = '0;
    st_raw       = '0;
    st_tare      = '0;
    st_status    = '0;
    burst_left   = 1;
    hold_request = 1'b0;
    gen_ms       = 32'hffff_ff00;
    rst_ni       = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_poll_cycle();
    test_tare_saturation();
    test_output_stall();

    // Default registers, then the widest range with the longest wait.
    set_config(OUT_MIN_RST, OUT_MAX_RST, 0, 30000, TARE_LIM_RST, CONV_T_RST);
    test_random_traffic(200);
    set_config(24'h000000, 24'hffffff, -2000000, 2000000, 21'd2000000, 8'd255);
    test_random_traffic(100);
    // Reversed spans with no tare tolerance and no wait.
    set_config(24'hffffff, 24'h000000, 2000000, -2000000, 21'd0, 8'd0);
    test_random_traffic(100);
    // Zero count span: every frame reads the range minimum.
    set_config(24'h123456, 24'h123456, -1500, 1500, 21'd2000, 8'd1);
    test_random_traffic(80);
    test_random_settings(3, 120);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_readings.size() != 0)
      report_mismatch("missing results", 32'(pending_readings.size()), '0);

    $display("Covered %0d requests and %0d results over %0d register settings,",
             requests_sent, readings_checked, config_phases);
    $display("with %0d converted frames, %0d refused zero requests, %0d long stalls.",
             frames_converted, zeros_refused, long_holds);
    if (errors == 0) begin
      $display("pressure_sensor_poll_convert_tare_core: match");
    end else begin
      $display("pressure_sensor_poll_convert_tare_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
